// ===== rtl/pht_pkg.sv =====
// Package: shared types and constants of the polygon hit tester.
package pht_pkg;

  localparam int unsigned CoordW = 18;
  localparam int unsigned SlotW  = 6;
  localparam int unsigned RadW   = 17;
  localparam int unsigned TagW   = 16;
  localparam int unsigned CountW = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 17;

  typedef enum logic [CfgIdxW-1:0] {
    CfgVertexCount = 2'd0,
    CfgIsClosed    = 2'd1,
    CfgHitRadius   = 2'd2,
    CfgSurfaceTag  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KindNone   = 2'd0,
    KindVertex = 2'd1,
    KindEdge   = 2'd2,
    KindBody   = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    StIdle,
    StVxRead,
    StVxCalc,
    StVxCmp,
    StEdRead,
    StEdCalc1,
    StEdCalc2,
    StEdCalc3,
    StEdCmp,
    StBdRead,
    StBdCalc,
    StBdCmp,
    StDone
  } state_e;

  // Output item as packed in m_axis_tdata: hit, kind, index, surface, x, y.
  typedef struct packed {
    logic signed [CoordW-1:0] echo_y;
    logic signed [CoordW-1:0] echo_x;
    logic [TagW-1:0]          hit_surface;
    logic [SlotW-1:0]         handle_index;
    kind_e                    handle_kind;
    logic                     hit;
  } result_t;

endpackage

// ===== rtl/polygon_hit_tester_top.sv =====
// Top level: vertex memory and the three-pass hit test sequencer.
//
// Usage: s_axis carries input transactions. tdata bits, lowest first:
// action[0], vertex_slot[6:1], vertex_x[24:7], vertex_y[42:25],
// query_x[60:43], query_y[78:61], zero padding to 80 bits.
// A vertex write (action 0) stores one table entry and yields no result.
// A query (action 1) yields one m_axis transaction: hit, handle_kind,
// handle_index, hit_surface, echo_x, echo_y (61 bits, padded to 64).
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must write it only while idle, which the block itself does not enforce.
// A write is taken while idle and the next transaction may follow at once.
// A query walks the vertex memory through its single read port: a vertex
// pass, then an edge pass with two reads and a four-step wide product per
// edge, then a body pass that begins by fetching the first vertex pair, and
// last the result is loaded; an early hit ends the walk sooner. The single
// read port and the stepped wide products set the query time.
// A finished result waits in the output register and holds the input off
// while the receiver stalls; the block takes the next transaction as soon
// as the register is free or being drained.
// Reset clears control state and restores register defaults; the vertex
// memory is not cleared and needs writing before it is queried.
module polygon_hit_tester_top
  import pht_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // action, vertex_slot, vertex_x, vertex_y, query_x, query_y, from bit 0
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // hit, handle_kind, handle_index, hit_surface, echo_x, echo_y, from bit 0
  output logic [63:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AddrW = $clog2(MAX_VERTICES);
  localparam int unsigned NW    = $clog2(MAX_VERTICES + 1);
  localparam int unsigned HalfW = CoordW + 1;
  localparam int unsigned WideW = 2*(2*CoordW+4);

  // configuration registers
  logic [CountW-1:0] vcount_q;
  logic              closed_q;
  logic [RadW-1:0]   radius_q;
  logic [TagW-1:0]   tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= '0;
      closed_q <= 1'b1;
      radius_q <= RadW'(655);
      tag_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgVertexCount: vcount_q <= cfg_data_i[CountW-1:0];
        CfgIsClosed:    closed_q <= cfg_data_i[0];
        CfgHitRadius:   radius_q <= cfg_data_i[RadW-1:0];
        CfgSurfaceTag:  tag_q    <= cfg_data_i[TagW-1:0];
        default: ;
      endcase
    end
  end

  // input unpack
  logic                     in_action;
  logic [SlotW-1:0]         in_slot;
  logic signed [CoordW-1:0] in_vx, in_vy, in_qx, in_qy;
  assign in_action = s_axis_tdata[0];
  assign in_slot   = s_axis_tdata[6:1];
  assign in_vx     = s_axis_tdata[24:7];
  assign in_vy     = s_axis_tdata[42:25];
  assign in_qx     = s_axis_tdata[60:43];
  assign in_qy     = s_axis_tdata[78:61];

  // vertex memory, x and y in one word, one read port
  logic [2*CoordW-1:0] mem_q [MAX_VERTICES];
  logic [2*CoordW-1:0] rdata_q;
  logic [AddrW-1:0]    raddr;
  logic                wr_en;

  assign wr_en = s_axis_tvalid && s_axis_tready && !in_action &&
                 (int'(in_slot) < MAX_VERTICES);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[AddrW'(in_slot)] <= {in_vy, in_vx};
    end
    rdata_q <= mem_q[raddr];
  end

  logic signed [CoordW-1:0] rd_x, rd_y;
  assign rd_x = rdata_q[CoordW-1:0];
  assign rd_y = rdata_q[2*CoordW-1:CoordW];

  // sequencer state
  state_e state_q, state_d;
  logic [NW-1:0] n_q, n_d;
  logic [NW-1:0] i_q, i_d;
  logic          second_q, second_d;   // second read of an edge pair
  logic signed [CoordW-1:0] qx_q, qx_d, qy_q, qy_d;
  logic signed [CoordW-1:0] ax_q, ax_d, ay_q, ay_d, bx_q, bx_d, by_q, by_d;
  logic          in_poly_q, in_poly_d;
  logic          ovalid_q, ovalid_d;
  result_t       res_q, res_d;

  // arithmetic registers
  logic signed [CoordW+1:0] ex_q, ey_q, dx_q, dy_q, fx_q, fy_q;
  logic signed [CoordW+1:0] ex_d, ey_d, dx_d, dy_d, fx_d, fy_d;
  logic [2*CoordW+4:0] pa_q, pa_d, pb_q, pb_d;          // squares sums
  logic signed [2*CoordW+4:0] dot_q, dot_d, crs_q, crs_d;
  logic signed [2*CoordW+4:0] len2_q, len2_d;
  logic [2*RadW-1:0] rr_q;
  // cross^2 and rr*len2, accumulated from half-width partials in four steps
  logic [WideW-1:0] c2_q, c2_d, r2_q, r2_d;
  logic [1:0]       part_q, part_d;
  logic          bhit_q, bhit_d;

  logic [NW-1:0] n_sat;
  assign n_sat = (int'(vcount_q) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vcount_q);

  always_ff @(posedge clk_i) begin
    rr_q <= radius_q * radius_q;
  end

  // operands of the stepped wide products
  logic [2*HalfW-1:0] cmag, rr_w, len_w;
  logic [HalfW-1:0]   c_a, c_b, r_a, r_b;
  logic [2*HalfW-1:0] c_pp, r_pp;
  logic [6:0]         pp_sh;
  logic [WideW-1:0]   c_term, r_term;

  assign cmag  = (crs_q < 0) ? (2*HalfW)'(-crs_q) : (2*HalfW)'(crs_q);
  assign rr_w  = (2*HalfW)'(rr_q);
  assign len_w = (2*HalfW)'(len2_q);

  always_comb begin
    c_a = cmag[HalfW-1:0];
    c_b = cmag[HalfW-1:0];
    r_a = rr_w[HalfW-1:0];
    r_b = len_w[HalfW-1:0];
    pp_sh = 7'd0;
    case (part_q)
      2'd1: begin
        c_b = cmag[2*HalfW-1:HalfW]; r_b = len_w[2*HalfW-1:HalfW];
        pp_sh = 7'(HalfW);
      end
      2'd2: begin
        c_a = cmag[2*HalfW-1:HalfW]; r_a = rr_w[2*HalfW-1:HalfW];
        pp_sh = 7'(HalfW);
      end
      2'd3: begin
        c_a = cmag[2*HalfW-1:HalfW]; c_b = cmag[2*HalfW-1:HalfW];
        r_a = rr_w[2*HalfW-1:HalfW]; r_b = len_w[2*HalfW-1:HalfW];
        pp_sh = 7'(2*HalfW);
      end
      default: ;
    endcase
  end

  assign c_pp   = c_a * c_b;
  assign r_pp   = r_a * r_b;
  assign c_term = WideW'(c_pp) << pp_sh;
  assign r_term = WideW'(r_pp) << pp_sh;

  logic out_free;
  assign out_free = !ovalid_q || m_axis_tready;
  assign s_axis_tready = (state_q == StIdle) && out_free;

  logic [NW-1:0] i_next;
  assign i_next = i_q + NW'(1);

  always_comb begin
    state_d = state_q; n_d = n_q; i_d = i_q; second_d = second_q;
    qx_d = qx_q; qy_d = qy_q;
    ax_d = ax_q; ay_d = ay_q; bx_d = bx_q; by_d = by_q;
    in_poly_d = in_poly_q; res_d = res_q; ovalid_d = ovalid_q;
    ex_d = ex_q; ey_d = ey_q; dx_d = dx_q; dy_d = dy_q; fx_d = fx_q; fy_d = fy_q;
    pa_d = pa_q; pb_d = pb_q; dot_d = dot_q; crs_d = crs_q; len2_d = len2_q;
    c2_d = c2_q; r2_d = r2_q; part_d = part_q; bhit_d = bhit_q;
    raddr = i_q[AddrW-1:0];
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;

    case (state_q)
      StIdle: begin
        if (s_axis_tvalid && out_free && in_action) begin
          qx_d = in_qx; qy_d = in_qy; n_d = n_sat; i_d = '0;
          in_poly_d = 1'b0;
          res_d = '0;
          res_d.echo_x = in_qx; res_d.echo_y = in_qy;
          state_d = (n_sat == '0) ? StDone : StVxRead;
        end
      end
      // vertex pass
      StVxRead: state_d = StVxCalc;
      StVxCalc: begin
        ex_d = (CoordW+2)'(qx_q) - (CoordW+2)'(rd_x);
        ey_d = (CoordW+2)'(qy_q) - (CoordW+2)'(rd_y);
        state_d = StVxCmp;
      end
      StVxCmp: begin
        if ((2*CoordW+5)'(ex_q*ex_q) + (2*CoordW+5)'(ey_q*ey_q) < (2*CoordW+5)'(rr_q)) begin
          res_d.hit = 1'b1; res_d.handle_kind = KindVertex;
          res_d.handle_index = SlotW'(i_q); res_d.hit_surface = tag_q;
          state_d = StDone;
        end else if (i_next == n_q) begin
          i_d = '0; second_d = 1'b0;
          state_d = (!closed_q && n_q == NW'(1)) ? StDone : StEdRead;
        end else begin
          i_d = i_next; state_d = StVxRead;
        end
      end
      // edge pass: read start then end vertex
      StEdRead: begin
        raddr = second_q ? ((i_next == n_q) ? '0 : i_next[AddrW-1:0])
                         : i_q[AddrW-1:0];
        state_d = StEdCalc1;
      end
      StEdCalc1: begin
        if (!second_q) begin
          ax_d = rd_x; ay_d = rd_y; second_d = 1'b1; state_d = StEdRead;
        end else begin
          bx_d = rd_x; by_d = rd_y; second_d = 1'b0;
          dx_d = (CoordW+2)'(rd_x) - (CoordW+2)'(ax_q);
          dy_d = (CoordW+2)'(rd_y) - (CoordW+2)'(ay_q);
          ex_d = (CoordW+2)'(qx_q) - (CoordW+2)'(ax_q);
          ey_d = (CoordW+2)'(qy_q) - (CoordW+2)'(ay_q);
          fx_d = (CoordW+2)'(qx_q) - (CoordW+2)'(rd_x);
          fy_d = (CoordW+2)'(qy_q) - (CoordW+2)'(rd_y);
          state_d = StEdCalc2;
        end
      end
      StEdCalc2: begin
        len2_d = (2*CoordW+5)'(dx_q*dx_q) + (2*CoordW+5)'(dy_q*dy_q);
        dot_d  = (2*CoordW+5)'(ex_q*dx_q) + (2*CoordW+5)'(ey_q*dy_q);
        crs_d  = (2*CoordW+5)'(ex_q*dy_q) - (2*CoordW+5)'(ey_q*dx_q);
        pa_d   = (2*CoordW+5)'(ex_q*ex_q) + (2*CoordW+5)'(ey_q*ey_q);
        pb_d   = (2*CoordW+5)'(fx_q*fx_q) + (2*CoordW+5)'(fy_q*fy_q);
        c2_d   = '0;
        r2_d   = '0;
        part_d = '0;
        state_d = StEdCalc3;
      end
      StEdCalc3: begin
        // accumulate one half-width partial product per cycle
        c2_d = c2_q + c_term;
        r2_d = r2_q + r_term;
        if (part_q == 2'd3) state_d = StEdCmp;
        else                part_d = part_q + 2'd1;
      end
      StEdCmp: begin
        if (len2_q == '0 || dot_q <= 0) bhit_d = pa_q < (2*CoordW+5)'(rr_q);
        else if (dot_q >= len2_q)       bhit_d = pb_q < (2*CoordW+5)'(rr_q);
        else                            bhit_d = c2_q < r2_q;
        if (bhit_d) begin
          res_d.hit = 1'b1; res_d.handle_kind = KindEdge;
          res_d.handle_index = SlotW'(i_q); res_d.hit_surface = tag_q;
          state_d = StDone;
        end else if (i_next == n_q || (!closed_q && i_next == n_q - NW'(1))) begin
          i_d = '0;
          state_d = (closed_q && n_q >= NW'(3)) ? StBdRead : StDone;
        end else begin
          i_d = i_next; state_d = StEdRead;
        end
      end
      // body pass: edge (j = i-1, i); a holds previous vertex
      StBdRead: begin
        raddr = (i_q == '0 && !second_q) ? AddrW'(n_q - NW'(1)) : i_q[AddrW-1:0];
        state_d = StBdCalc;
      end
      StBdCalc: begin
        if (i_q == '0 && !second_q) begin
          ax_d = rd_x; ay_d = rd_y; second_d = 1'b1; state_d = StBdRead;
          raddr = '0;
        end else begin
          // b = vertex i, a = vertex j
          bx_d = rd_x; by_d = rd_y;
          dx_d = (CoordW+2)'(ax_q) - (CoordW+2)'(rd_x);          // xj - xi
          dy_d = (CoordW+2)'(ay_q) - (CoordW+2)'(rd_y);          // den
          ex_d = (CoordW+2)'(qy_q) - (CoordW+2)'(rd_y);          // py - yi
          fx_d = (CoordW+2)'(qx_q) - (CoordW+2)'(rd_x);          // px - xi
          bhit_d = (rd_y > qy_q) != (ay_q > qy_q);
          state_d = StBdCmp;
        end
      end
      StBdCmp: begin
        dot_d = (2*CoordW+5)'(dx_q*ex_q);
        crs_d = (2*CoordW+5)'(fx_q*dy_q);
        if (bhit_q && ((dy_q > 0) ? (crs_d < dot_d) : (crs_d > dot_d)))
          in_poly_d = !in_poly_q;
        ax_d = bx_q; ay_d = by_q; second_d = 1'b0;
        if (i_next == n_q) begin
          if (in_poly_d) begin
            res_d.hit = 1'b1; res_d.handle_kind = KindBody; res_d.hit_surface = tag_q;
          end
          state_d = StDone;
        end else begin
          i_d = i_next; state_d = StBdRead;
          raddr = i_next[AddrW-1:0];
        end
      end
      StDone: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1; state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; i_q <= i_d; second_q <= second_d;
    qx_q <= qx_d; qy_q <= qy_d;
    ax_q <= ax_d; ay_q <= ay_d; bx_q <= bx_d; by_q <= by_d;
    in_poly_q <= in_poly_d; res_q <= res_d;
    ex_q <= ex_d; ey_q <= ey_d; dx_q <= dx_d; dy_q <= dy_d; fx_q <= fx_d; fy_q <= fy_d;
    pa_q <= pa_d; pb_q <= pb_d; dot_q <= dot_d; crs_q <= crs_d; len2_q <= len2_d;
    c2_q <= c2_d; r2_q <= r2_d; part_q <= part_d; bhit_q <= bhit_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {{(64-$bits(result_t)){1'b0}}, res_q};

endmodule

// ===== rtl/pht_checker.sv =====
// Checker: port-level properties of the polygon hit tester, and its bind.
module pht_checker
  import pht_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [79:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");

  a_hit_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[2:1] != 2'd0)))
    else $error("hit flag disagrees with kind");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[24:3] == '0)
    else $error("miss carries index or surface");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tdata[0] |=> !s_axis_tready)
    else $error("query accepted while busy");

endmodule

bind polygon_hit_tester_top pht_checker u_pht_checker (.*);
